### hw/rtl/rwc_pkg.sv
// ----------------------------------------------------------------------------
// rwc_pkg: shared types and constants of the rolling window checksum
// Command and status codes, result beat layout, per-item control flags.
// ----------------------------------------------------------------------------
package rwc_pkg;

  localparam int unsigned SUM_W   = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CKSUM_W = 32;
  localparam int unsigned FILL_W  = 13;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned STAT_W  = 2;
  // product of occupancy and a byte, split into three byte chunks for reduction
  localparam int unsigned PROD_W  = 24;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PUSH  = 2'd1,
    CMD_POP   = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic clr;
    logic push;
    logic pop;
  } ops_t;

  typedef struct packed {
    logic [CKSUM_W-1:0] checksum;
    logic [FILL_W-1:0]  fill_count;
    logic [BYTE_W-1:0]  removed_byte;
    status_e            status;
  } result_t;

endpackage

### hw/rtl/rolling_window_checksum.sv
// ----------------------------------------------------------------------------
// rolling_window_checksum: rsync-style weak rolling checksum over a byte FIFO
//
// Input channel (in_valid_i / in_stall_o) carries cmd_i and data_byte_i:
// clear, push a byte, or pop the oldest byte. Every accepted beat yields
// exactly one beat on the output channel (out_valid_o / out_stall_i) with
// checksum_o = {b, a}, fill_count_o, removed_byte_o and status_o.
// A beat is accepted when valid is high and stall is low.
// The result is registered (output register, or skid entry while stalled).
// Throughput is one beat per cycle while in_stall_o is low; the oldest byte
// is prefetched from the window RAM (one read port) so pops can run back to
// back, and the pop update is one 13x8 multiply plus table reduction.
// When the receiver stalls, the output register holds its beat and a skid
// entry takes one more; in_stall_o rises only once the skid entry is full.
// Reset empties the window, zeroes both sums and the last removed byte and
// drops any pending result. The window RAM is not cleared; no entry is read
// before a push has written it.
// ----------------------------------------------------------------------------
module rolling_window_checksum import rwc_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 4096,
  parameter int unsigned MODULUS      = 65536
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CMD_W-1:0]   cmd_i,
  input  logic [BYTE_W-1:0]  data_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CKSUM_W-1:0] checksum_o,
  output logic [FILL_W-1:0]  fill_count_o,
  output logic [BYTE_W-1:0]  removed_byte_o,
  output logic [STAT_W-1:0]  status_o
);

  localparam int unsigned OCC_W = $clog2(WINDOW_DEPTH + 1);

  logic              accept;
  ops_t              ops;
  logic [OCC_W-1:0]  occ, occ_d;
  logic [BYTE_W-1:0] head_byte, last_d;
  logic [SUM_W-1:0]  sum_a_d, sum_b_d;
  status_e           status;
  result_t           res, res_out;

  assign accept = in_valid_i && !in_stall_o;

  rwc_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .cmd_i       (cmd_i),
    .data_byte_i (data_byte_i),
    .ops_o       (ops),
    .occ_o       (occ),
    .head_byte_o (head_byte),
    .occ_d_o     (occ_d),
    .last_d_o    (last_d),
    .status_o    (status)
  );

  rwc_sums #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .MODULUS      (MODULUS)
  ) u_sums (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ops_i       (ops),
    .data_byte_i (data_byte_i),
    .head_byte_i (head_byte),
    .occ_i       (occ),
    .sum_a_d_o   (sum_a_d),
    .sum_b_d_o   (sum_b_d)
  );

  always_comb begin
    res.checksum     = {sum_b_d, sum_a_d};
    res.fill_count   = FILL_W'(occ_d);
    res.removed_byte = last_d;
    res.status       = status;
  end

  rwc_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .in_data_i   (res),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (res_out)
  );

  assign checksum_o     = res_out.checksum;
  assign fill_count_o   = res_out.fill_count;
  assign removed_byte_o = res_out.removed_byte;
  assign status_o       = res_out.status;

endmodule

### hw/rtl/rwc_ram.sv
// ----------------------------------------------------------------------------
// rwc_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rwc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/rwc_window.sv
// ----------------------------------------------------------------------------
// rwc_window: byte window FIFO
// Decodes the command, keeps head/tail/occupancy, and presents the oldest
// byte every cycle (RAM read of the next head, plus a bypass for a push
// that lands on that address in the same cycle).
// ----------------------------------------------------------------------------
module rwc_window import rwc_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 4096,
  localparam int unsigned PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
  localparam int unsigned OCC_W = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  output ops_t              ops_o,
  output logic [OCC_W-1:0]  occ_o,
  output logic [BYTE_W-1:0] head_byte_o,
  output logic [OCC_W-1:0]  occ_d_o,
  output logic [BYTE_W-1:0] last_d_o,
  output status_e           status_o
);

  localparam logic [PTR_W-1:0] PtrLast = PTR_W'(WINDOW_DEPTH - 1);
  localparam logic [OCC_W-1:0] OccFull = OCC_W'(WINDOW_DEPTH);

  logic [PTR_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [OCC_W-1:0]  occ_q, occ_d;
  logic [BYTE_W-1:0] last_q, last_d;
  logic              byp_vld_q, byp_vld_d;
  logic [BYTE_W-1:0] byp_data_q;
  logic [BYTE_W-1:0] rdata;
  logic              full, empty;
  ops_t              ops;
  status_e           status;

  assign full  = (occ_q == OccFull);
  assign empty = (occ_q == '0);

  always_comb begin
    ops    = '0;
    status = ST_OK;
    case (cmd_e'(cmd_i))
      CMD_CLEAR: ops.clr = accept_i;
      CMD_PUSH: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ops.push = accept_i;
        end
      end
      CMD_POP: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          ops.pop = accept_i;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    occ_d  = occ_q;
    if (ops.clr) begin
      head_d = '0;
      tail_d = '0;
      occ_d  = '0;
    end else if (ops.push) begin
      tail_d = (tail_q == PtrLast) ? '0 : tail_q + 1'b1;
      occ_d  = occ_q + 1'b1;
    end else if (ops.pop) begin
      head_d = (head_q == PtrLast) ? '0 : head_q + 1'b1;
      occ_d  = occ_q - 1'b1;
    end
  end

  // RAM read misses a write issued in the same cycle to the same address
  assign byp_vld_d   = ops.push && (tail_q == head_d);
  assign head_byte_o = byp_vld_q ? byp_data_q : rdata;
  assign last_d      = ops.pop ? head_byte_o : last_q;

  rwc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ops.push),
    .waddr_i (tail_q),
    .wdata_i (data_byte_i),
    .raddr_i (head_d),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      occ_q     <= '0;
      last_q    <= '0;
      byp_vld_q <= 1'b0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      occ_q     <= occ_d;
      last_q    <= last_d;
      byp_vld_q <= byp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= data_byte_i;
  end

  assign ops_o    = ops;
  assign occ_o    = occ_q;
  assign occ_d_o  = occ_d;
  assign last_d_o = last_d;
  assign status_o = status;

endmodule

### hw/rtl/rwc_sums.sv
// ----------------------------------------------------------------------------
// rwc_sums: running sums a and b modulo MODULUS
// Push: a += byte, b += new a. Pop: a -= byte, b -= occupancy*byte.
// The product is reduced with three constant tables of chunk residues.
// ----------------------------------------------------------------------------
module rwc_sums import rwc_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 4096,
  parameter int unsigned MODULUS      = 65536,
  localparam int unsigned OCC_W = $clog2(WINDOW_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ops_t              ops_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic [BYTE_W-1:0] head_byte_i,
  input  logic [OCC_W-1:0]  occ_i,
  output logic [SUM_W-1:0]  sum_a_d_o,
  output logic [SUM_W-1:0]  sum_b_d_o
);

  localparam logic [SUM_W:0]   M17 = (SUM_W + 1)'(MODULUS);
  localparam logic [SUM_W+1:0] M18 = (SUM_W + 2)'(MODULUS);
  localparam logic [SUM_W+1:0] M2x = (SUM_W + 2)'(2 * MODULUS);

  logic [SUM_W-1:0] sum_a_q, sum_a_d, sum_b_q, sum_b_d;
  logic [SUM_W-1:0] tab0 [256];
  logic [SUM_W-1:0] tab1 [256];
  logic [SUM_W-1:0] tab2 [256];

  // residues of g, g*2^8 and g*2^16
  for (genvar g = 0; g < 256; g++) begin : g_tab
    localparam int unsigned R0 = g % MODULUS;
    localparam int unsigned R1 = (g * 256) % MODULUS;
    localparam int unsigned R2 = (g * 65536) % MODULUS;
    assign tab0[g] = SUM_W'(R0);
    assign tab1[g] = SUM_W'(R1);
    assign tab2[g] = SUM_W'(R2);
  end

  logic [SUM_W-1:0]   data_m, head_m, red_m;
  logic [SUM_W:0]     a_sum, a_push, b_sum, b_push, a_pop, b_pop;
  logic [OCC_W+7:0]   prod;
  logic [PROD_W-1:0]  prod_x;
  logic [SUM_W+1:0]   red;

  assign data_m = tab0[data_byte_i];
  assign head_m = tab0[head_byte_i];

  assign a_sum  = {1'b0, sum_a_q} + {1'b0, data_m};
  assign a_push = (a_sum >= M17) ? a_sum - M17 : a_sum;
  assign b_sum  = {1'b0, sum_b_q} + {1'b0, a_push[SUM_W-1:0]};
  assign b_push = (b_sum >= M17) ? b_sum - M17 : b_sum;

  assign a_pop = (sum_a_q >= head_m) ? {1'b0, sum_a_q} - {1'b0, head_m}
                                     : {1'b0, sum_a_q} + M17 - {1'b0, head_m};

  assign prod   = occ_i * head_byte_i;
  assign prod_x = PROD_W'(prod);
  assign red    = (SUM_W + 2)'(tab0[prod_x[7:0]]) + (SUM_W + 2)'(tab1[prod_x[15:8]])
                + (SUM_W + 2)'(tab2[prod_x[23:16]]);

  // red < 3*M, so at most two subtractions of M
  always_comb begin
    if (red >= M2x) begin
      red_m = SUM_W'(red - M2x);
    end else if (red >= M18) begin
      red_m = SUM_W'(red - M18);
    end else begin
      red_m = SUM_W'(red);
    end
  end

  assign b_pop = (sum_b_q >= red_m) ? {1'b0, sum_b_q} - {1'b0, red_m}
                                    : {1'b0, sum_b_q} + M17 - {1'b0, red_m};

  always_comb begin
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    if (ops_i.clr) begin
      sum_a_d = '0;
      sum_b_d = '0;
    end else if (ops_i.push) begin
      sum_a_d = a_push[SUM_W-1:0];
      sum_b_d = b_push[SUM_W-1:0];
    end else if (ops_i.pop) begin
      sum_a_d = a_pop[SUM_W-1:0];
      sum_b_d = b_pop[SUM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_a_q <= '0;
      sum_b_q <= '0;
    end else begin
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
    end
  end

  assign sum_a_d_o = sum_a_d;
  assign sum_b_d_o = sum_b_d;

endmodule

### hw/rtl/rwc_outq.sv
// ----------------------------------------------------------------------------
// rwc_outq: result register with skid entry
// Holds one beat for the receiver and catches one more while it stalls;
// the upstream stall comes straight from a flop.
// ----------------------------------------------------------------------------
module rwc_outq import rwc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  result_t in_data_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  logic    main_vld_q, main_vld_d, skid_vld_q, skid_vld_d;
  result_t main_q, main_d, skid_q, skid_d;
  logic    main_load;

  assign main_load = !main_vld_q || !out_stall_i;

  always_comb begin
    main_vld_d = main_vld_q;
    main_d     = main_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (main_load) begin
      if (skid_vld_q) begin
        main_vld_d = 1'b1;
        main_d     = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        main_vld_d = in_valid_i;
        main_d     = in_data_i;
      end
    end else if (in_valid_i) begin
      skid_vld_d = 1'b1;
      skid_d     = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign in_stall_o  = skid_vld_q;
  assign out_valid_o = main_vld_q;
  assign out_data_o  = main_q;

endmodule

### hw/rtl/rwc_checker.sv
// ----------------------------------------------------------------------------
// rwc_checker: port-level assertions for the rolling window checksum
// Bound to the top level; watches the channels and the result fields.
// ----------------------------------------------------------------------------
module rwc_checker import rwc_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 4096
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [CKSUM_W-1:0] checksum_o,
  input logic [FILL_W-1:0]  fill_count_o,
  input logic [BYTE_W-1:0]  removed_byte_o,
  input logic [STAT_W-1:0]  status_o
);

  localparam logic [FILL_W-1:0] FillFull = FILL_W'(WINDOW_DEPTH);

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(checksum_o)
      && $stable(fill_count_o) && $stable(removed_byte_o) && $stable(status_o))
    else $error("result beat changed while stalled");

  // input is only held off when a result is pending
  a_stall_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> (fill_count_o == '0))
    else $error("empty-pop status with nonzero fill");

  a_full_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> (fill_count_o == FillFull))
    else $error("full-push status with window not full");

  // both sums drain to zero with the window, so an empty-pop beat reads zero
  a_empty_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i ##1 out_valid_o && (status_o == ST_EMPTY)
      |-> (checksum_o == '0))
    else $error("empty window with nonzero checksum");

endmodule

bind rolling_window_checksum rwc_checker #(
  .WINDOW_DEPTH (WINDOW_DEPTH)
) u_rwc_checker (.*);

### dv/rolling_window_checksum_test.sv
// ----------------------------------------------------------------------------
// rolling_window_checksum_test: self-checking bench for the rolling checksum
// A queue of command beats feeds a bursty driver; a monitor compares every
// result beat against a local model of the sums and the byte window. The
// receiver stalls on its own pattern, including one long hold-off.
// ----------------------------------------------------------------------------
module rolling_window_checksum_test;
  import rwc_pkg::*;

  localparam int unsigned DEPTH      = 4096;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned HOLD_AT_BEAT = 300;
  localparam int unsigned RAND_ITEMS = 540;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data;
  } cmd_beat_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [CMD_W-1:0]   cmd_i = '0;
  logic [BYTE_W-1:0]  data_byte_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [CKSUM_W-1:0] checksum_o;
  logic [FILL_W-1:0]  fill_count_o;
  logic [BYTE_W-1:0]  removed_byte_o;
  logic [STAT_W-1:0]  status_o;

  cmd_beat_t   cmd_beats[$];
  result_t     predicted_sums[$];
  int unsigned err_cnt = 0;
  int unsigned idle_cycles = 0;

  // local copy of the checksum state
  logic [SUM_W-1:0]  sum_a, sum_b;
  logic [BYTE_W-1:0] window_mem [DEPTH];
  logic [11:0]       head_ptr;
  logic [FILL_W-1:0] fill;
  logic [BYTE_W-1:0] last_popped;

  rolling_window_checksum DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .checksum_o    (checksum_o),
    .fill_count_o  (fill_count_o),
    .removed_byte_o(removed_byte_o),
    .status_o      (status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic result_t roll_checksum(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b);
    result_t           r;
    status_e           st;
    logic [11:0]       tail;
    logic [BYTE_W-1:0] oldest;
    logic [PROD_W-1:0] prod;
    st = ST_OK;
    case (cmd)
      CMD_CLEAR: begin
        sum_a = '0;
        sum_b = '0;
        head_ptr = '0;
        fill = '0;
      end
      CMD_PUSH: begin
        if (fill >= DEPTH) begin
          st = ST_FULL;
        end else begin
          tail = head_ptr + fill[11:0];
          window_mem[tail] = b;
          fill = fill + 1'b1;
          sum_a = sum_a + b;
          sum_b = sum_b + sum_a;
        end
      end
      CMD_POP: begin
        if (fill == 0) begin
          st = ST_EMPTY;
        end else begin
          oldest = window_mem[head_ptr];
          // b drops by the pre-pop fill times the byte, mod 2^16
          prod = fill * oldest;
          sum_a = sum_a - oldest;
          sum_b = sum_b - prod[SUM_W-1:0];
          last_popped = oldest;
          head_ptr = head_ptr + 1'b1;
          fill = fill - 1'b1;
        end
      end
      default: ;
    endcase
    r.checksum = {sum_b, sum_a};
    r.fill_count = fill;
    r.removed_byte = last_popped;
    r.status = st;
    return r;
  endfunction

  task automatic add_beat(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data);
    cmd_beat_t c;
    c.cmd = cmd;
    c.data = data;
    cmd_beats.insert(cmd_beats.size(), c);
  endtask

  task automatic check_field(string what, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      err_cnt++;
      $display("%0t: %s mismatch: expected %h, actual %h", $realtime, what, exp_v, act_v);
    end
  endtask

  // ---------------------------------------------------------------- driver
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    cmd_beat_t   c;
    logic        nxt_valid;
    logic [CMD_W-1:0]  nxt_cmd;
    logic [BYTE_W-1:0] nxt_data;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cmd_i <= '0;
      data_byte_i <= '0;
    end else begin
      nxt_valid = in_valid_i;
      nxt_cmd = cmd_i;
      nxt_data = data_byte_i;
      if (in_valid_i && !in_stall_o)
        predicted_sums.insert(predicted_sums.size(), roll_checksum(cmd_i, data_byte_i));
      if (!in_valid_i || !in_stall_o) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_beats.size() > 0) begin
          c = cmd_beats.pop_front();
          nxt_valid = 1'b1;
          nxt_cmd = c.cmd;
          nxt_data = c.data;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_valid_i <= nxt_valid;
      cmd_i <= nxt_cmd;
      data_byte_i <= nxt_data;
    end
  end

  // -------------------------------------------------------- receiver stall
  int unsigned stall_mode = 0;
  int unsigned mode_left = 64;
  int unsigned hold_left = 0;
  int unsigned out_beats = 0;
  logic        hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt_stall;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) out_beats++;
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      // one long hold-off so the skid entry fills and the input backs up
      if (!hold_done && out_beats >= HOLD_AT_BEAT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_stall = 1'b1;
      end else begin
        case (stall_mode)
          0: nxt_stall = 1'b0;
          1: nxt_stall = ($urandom_range(0, 3) == 0);
          2: nxt_stall = ($urandom_range(0, 3) != 0);
          default: nxt_stall = ~out_stall_i;
        endcase
      end
      out_stall_i <= nxt_stall;
    end
  end

  // --------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_sums.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result beat: expected none, actual %h/%h/%h/%h",
                 $realtime, checksum_o, fill_count_o, removed_byte_o, status_o);
      end else begin
        exp_r = predicted_sums.pop_front();
        check_field("checksum", exp_r.checksum, checksum_o);
        check_field("fill_count", 32'(exp_r.fill_count), 32'(fill_count_o));
        check_field("removed_byte", 32'(exp_r.removed_byte), 32'(removed_byte_o));
        check_field("status", 32'(exp_r.status), 32'(status_o));
      end
    end
  end

  // -------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("%0t: timeout, no beat accepted for %0d cycles", $realtime, IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // -------------------------------------------------------------- stimulus
  initial begin
    int unsigned n_rand;
    int unsigned len;
    int unsigned k;
    int unsigned sel;
    logic [CMD_W-1:0] rc;

    sum_a = '0;
    sum_b = '0;
    head_ptr = '0;
    fill = '0;
    last_popped = '0;
    foreach (window_mem[i]) window_mem[i] = '0;

    // directed: empty pop, extreme bytes, pop past empty, unused code, clear
    add_beat(CMD_POP, 8'hA5);
    add_beat(CMD_PUSH, 8'h00);
    add_beat(CMD_PUSH, 8'hFF);
    add_beat(CMD_PUSH, 8'h80);
    add_beat(CMD_UNUSED, 8'hFF);
    add_beat(CMD_POP, 8'h00);
    add_beat(CMD_POP, 8'hFF);
    add_beat(CMD_POP, 8'h00);
    add_beat(CMD_POP, 8'h00);
    add_beat(CMD_PUSH, 8'hFF);
    add_beat(CMD_PUSH, 8'hFF);
    add_beat(CMD_PUSH, 8'hFF);
    add_beat(CMD_CLEAR, 8'hFF);
    add_beat(CMD_POP, 8'h00);      // empty after clear, removed byte held
    add_beat(CMD_PUSH, 8'h01);
    add_beat(CMD_UNUSED, 8'h00);
    add_beat(CMD_PUSH, 8'h7F);
    add_beat(CMD_POP, 8'h55);
    add_beat(CMD_CLEAR, 8'h00);

    // random: mostly push runs, half after a clear, with rolling push/pop
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++) begin
          rc = 2'($urandom_range(0, 3));
          add_beat(rc, 8'($urandom));
          n_rand++;
        end
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          add_beat(CMD_CLEAR, 8'($urandom));
          n_rand++;
        end
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 120) : $urandom_range(1, 40);
        for (k = 0; k < len; k++) add_beat(CMD_PUSH, 8'($urandom));
        n_rand += len;
        len = $urandom_range(5, 40);
        for (k = 0; k < len; k++)
          add_beat(($urandom_range(0, 9) < 6) ? CMD_PUSH : CMD_POP, 8'($urandom));
        n_rand += len;
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_beats.size() > 0 || in_valid_i || predicted_sums.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
